[src/tnc_pkg.sv]
// ----------------------------------------------------------------------------
// tnc_pkg
// Shared types and constants of the ttl negative cache: request and response
// payloads, controller state codes and the controller to datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package tnc_pkg;

	localparam int KEY_W  = 16;
	localparam int TIME_W = 32;
	localparam int TTL_W  = 31;

	localparam logic [TTL_W-1:0] TTL_RESET = 31'd60000;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_MARK   = 1'b1;

	typedef struct packed {
		logic              op;
		logic [KEY_W-1:0]  key;
		logic [TIME_W-1:0] now_ms;
	} req_t;

	typedef struct packed {
		logic missing;
		logic expired;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic decide;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_end;
	} dp_sts_t;

endpackage

`default_nettype wire

[src/tnc_ram.sv]
// ----------------------------------------------------------------------------
// tnc_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[src/tnc_ctrl.sv]
// ----------------------------------------------------------------------------
// tnc_ctrl
// Controller: takes a request, runs the scan, commits the outcome and holds
// the response valid until the response transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_ctrl
	import tnc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	output logic         rsp_valid,
	input  wire logic    rsp_ready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_end) begin
					cmd.decide = 1'b1;
					state_d    = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (rsp_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[src/tnc_dp.sv]
// ----------------------------------------------------------------------------
// tnc_dp
// Datapath: request registers, entry RAM, valid bits, replacement pointer,
// used count, scan pipeline with key match and age check, response register.
// ----------------------------------------------------------------------------
`default_nettype none

module tnc_dp
	import tnc_pkg::*;
#(
	parameter int ENTRIES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire req_t             req,
	input  wire logic             cfg_we,
	input  wire logic [TTL_W-1:0] cfg_wdata,
	input  wire dp_cmd_t          cmd,
	output dp_sts_t               sts,
	output rsp_t                  rsp
);

	localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW    = $clog2(ENTRIES + 1);
	localparam int DATA_W = KEY_W + TIME_W;

	req_t              req_q;
	logic [TTL_W-1:0]  ttl_q;
	logic [ENTRIES-1:0] valid_q;
	logic [AW-1:0]     ptr_q;
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     idx_q;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;
	logic              hit_q;
	logic              aged_q;
	logic [AW-1:0]     slot_q;
	rsp_t              rsp_q;

	logic              more;
	logic [DATA_W-1:0] rdata;
	logic [KEY_W-1:0]  rd_key;
	logic [TIME_W-1:0] rd_time;
	logic [TIME_W-1:0] age;
	logic              aged;
	logic              slot_vld;
	logic              hit_s1;
	logic              we;
	logic [AW-1:0]     waddr;

	assign more     = idx_q < used_q;
	assign rd_key   = rdata[DATA_W-1:TIME_W];
	assign rd_time  = rdata[TIME_W-1:0];
	assign age      = req_q.now_ms - rd_time;
	assign aged     = !age[TIME_W-1] && (age[TTL_W-1:0] >= ttl_q);
	assign slot_vld = valid_q[idx_s1];

	always_comb begin
		if (req_q.op == OP_MARK) begin
			hit_s1 = vld_s1 && !slot_vld;
		end else begin
			hit_s1 = vld_s1 && slot_vld && (rd_key == req_q.key);
		end
	end

	assign sts.scan_end = hit_s1 || (!more && !vld_s1);

	assign we    = cmd.commit && (req_q.op == OP_MARK);
	assign waddr = hit_q ? slot_q : ptr_q;

	tnc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({req_q.key, req_q.now_ms}),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	// request, scan pipeline and decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.issue) begin
				if (more) begin
					idx_q  <= idx_q + CW'(1);
					vld_s1 <= 1'b1;
				end else begin
					vld_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q <= req;
		end
		if (cmd.issue) begin
			idx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.decide) begin
			hit_q  <= hit_s1;
			aged_q <= aged;
			slot_q <= idx_s1;
		end
		if (cmd.commit) begin
			rsp_q.missing <= (req_q.op == OP_LOOKUP) && hit_q && !aged_q;
			rsp_q.expired <= (req_q.op == OP_LOOKUP) && hit_q && aged_q;
		end
	end

	// table state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q   <= TTL_RESET;
			valid_q <= '0;
			ptr_q   <= '0;
			used_q  <= '0;
		end else begin
			if (cfg_we) begin
				ttl_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (req_q.op == OP_MARK) begin
					valid_q[waddr] <= 1'b1;
					if (!hit_q) begin
						if (ptr_q == AW'(ENTRIES - 1)) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
						if (used_q < CW'(ENTRIES)) begin
							used_q <= used_q + CW'(1);
						end
					end
				end else if (hit_q && aged_q) begin
					valid_q[slot_q] <= 1'b0;
				end
			end
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

[src/ttl_negative_cache.sv]
// ----------------------------------------------------------------------------
// ttl_negative_cache
// Small table of keys recently found missing, each with a timestamp, checked
// against a configurable time to live.
// ----------------------------------------------------------------------------
// A request either looks up a key (op 0) or marks it missing (op 1). The
// used entries are scanned one per cycle from a registered-read RAM up to
// the first hit, and the outcome is then committed. A lookup that hits a
// live entry answers missing; one that hits an entry of age ttl_ms or more
// (wrap-safe, ages of 2^31 or more never expire) frees it and answers
// expired. A mark fills the first freed used slot, or else the round-robin
// slot. One request is in flight at a time; a waiting response does not
// block the next request transfer. ttl_ms is written through cfg_we/cfg_wdata
// and resets to 60000; the user must write it only while idle, which the
// block itself does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module ttl_negative_cache
	import tnc_pkg::*;
#(
	parameter int ENTRIES = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire req_t             req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_t                  rsp,
	input  wire logic             cfg_we,
	input  wire logic [TTL_W-1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tnc_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
